// File: design/stpg_pkg.sv
// Shared types and constants of the scope trace point generator.
// Used by every module in this folder; depends on nothing.
package stpg_pkg;

  // Width of a point coordinate on the result ports.
  localparam int unsigned PT_BITS = 16;
  // Width of the configuration write data (widest register).
  localparam int unsigned CFG_DATA_BITS = 32;
  // Records held between the front and back parts.
  localparam int unsigned QDEPTH = 4;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_X_SCALE,
    REG_X_OFFSET,
    REG_Y_GAIN,
    REG_VALUE_OFFSET,
    REG_Y_POSITION,
    REG_SCREEN_HEIGHT,
    REG_SAMPLE_TYPE,
    REG_CURSOR_COLUMN
  } stpg_reg_e;

  // Interpretation of the raw sample word.
  typedef enum logic [1:0] {
    STYPE_BIT,
    STYPE_REAL,
    STYPE_SIGNED,
    STYPE_UNSIGNED
  } stpg_stype_e;

  typedef struct packed {
    logic [23:0] x_scale;
    logic [31:0] x_offset;
    logic [31:0] y_gain;
    logic [31:0] value_offset;
    logic [15:0] y_position;
    logic [14:0] screen_height;
    stpg_stype_e sample_type;
    logic [16:0] cursor_column;
  } stpg_cfg_t;

  // Reset values of the registers.
  localparam logic [23:0] RST_X_SCALE       = 24'h010000;
  localparam logic [31:0] RST_X_OFFSET      = 32'h0000_0000;
  localparam logic [31:0] RST_Y_GAIN        = 32'hFFFF_0000;
  localparam logic [31:0] RST_VALUE_OFFSET  = 32'h0000_0000;
  localparam logic [15:0] RST_Y_POSITION    = 16'h0000;
  localparam logic [14:0] RST_SCREEN_HEIGHT = 15'd480;
  localparam logic [16:0] RST_CURSOR_COLUMN = 17'h08000;

  typedef struct packed {
    logic [PT_BITS-1:0] x;
    logic [PT_BITS-1:0] y;
  } stpg_pt_t;

  // All points caused by one sample, in emit order from slot 0.
  typedef struct packed {
    stpg_pt_t [2:0] pt;
    logic [1:0]     cnt;
    logic           hit;
  } stpg_rec_t;

endpackage

// File: design/stpg_front.sv
// Front part: maps samples to screen points in a stall-gated pipeline and
// turns each point into a record of polyline vertices. Depends on stpg_pkg.
module stpg_front import stpg_pkg::*; #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stpg_cfg_t             cfg_i,
  input  logic                  in_push_i,
  input  logic [31:0]           sample_raw_i,
  input  logic [INDEX_BITS-1:0] sample_index_i,
  input  logic                  record_start_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output stpg_rec_t             q_rec_o
);

  localparam int unsigned XPW = INDEX_BITS + 24;
  localparam int unsigned XW  = INDEX_BITS + 26;
  localparam int unsigned XQW = XW - 16;
  localparam int          CMAX_I = 2 ** (COORD_BITS - 1) - 1;
  localparam logic signed [COORD_BITS-1:0] C_MAX = COORD_BITS'(CMAX_I);
  localparam logic signed [COORD_BITS-1:0] C_MIN = COORD_BITS'(-CMAX_I - 1);
  localparam logic signed [XQW-1:0] XQ_MAX = XQW'(CMAX_I);
  localparam logic signed [XQW-1:0] XQ_MIN = XQW'(-CMAX_I - 1);
  localparam logic signed [20:0] YQ_MAX = 21'(CMAX_I);
  localparam logic signed [20:0] YQ_MIN = 21'(-CMAX_I - 1);

  // the whole pipeline moves only while the queue has room
  logic adv;
  assign adv = !q_full_i;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rs1_q, rs2_q, rs3_q, rs4_q, rs5_q, rs6_q;
  logic [XPW-1:0]               xprod1_q;
  logic signed [49:0]           diff1_q;
  logic signed [XW-1:0]         xs2_q;
  logic [48:0]                  a2_q;
  logic [31:0]                  b2_q;
  logic                         neg2_q, neg3_q, neg4_q;
  logic signed [COORD_BITS-1:0] px3_q, px4_q, px5_q, px6_q;
  logic [56:0]                  plo3_q;
  logic [55:0]                  phi3_q;
  logic [51:0]                  m4_q;
  logic signed [52:0]           s5_q;
  logic signed [COORD_BITS-1:0] py6_q;

  // stage 1: sample value in Q33.16, minus offset; x product
  logic signed [48:0] val1;
  logic signed [49:0] diff1_d;
  logic [XPW-1:0]     xprod1_d;
  always_comb begin
    unique case (cfg_i.sample_type)
      STYPE_BIT:      val1 = (sample_raw_i != 32'd0) ? 49'sd65536 : 49'sd0;
      STYPE_REAL:     val1 = 49'($signed(sample_raw_i));
      STYPE_SIGNED:   val1 = $signed({sample_raw_i[31], sample_raw_i, 16'h0000});
      STYPE_UNSIGNED: val1 = $signed({1'b0, sample_raw_i, 16'h0000});
    endcase
    diff1_d  = 50'(val1) - 50'($signed(cfg_i.value_offset));
    xprod1_d = XPW'(sample_index_i) * XPW'(cfg_i.x_scale);
  end

  // stage 2: x minus offset; magnitudes for the y product
  logic signed [XW-1:0] xs2_d;
  logic [48:0]          a2_d;
  logic [32:0]          gabs;
  logic signed [32:0]   gain33;
  always_comb begin
    xs2_d  = $signed({2'b00, xprod1_q}) - XW'($signed(cfg_i.x_offset));
    a2_d   = diff1_q[49] ? 49'(-diff1_q) : diff1_q[48:0];
    gain33 = 33'($signed(cfg_i.y_gain));
    gabs   = gain33[32] ? 33'(-gain33) : 33'(gain33);
  end

  // stage 3: y partial products; x truncated toward zero and clipped
  logic signed [XQW-1:0]        xq, xt;
  logic signed [COORD_BITS-1:0] px3_d;
  always_comb begin
    xq = xs2_q[XW-1:16];
    xt = xq + XQW'(xs2_q[XW-1] && (xs2_q[15:0] != 16'h0000));
    if (xt > XQ_MAX) begin
      px3_d = C_MAX;
    end else if (xt < XQ_MIN) begin
      px3_d = C_MIN;
    end else begin
      px3_d = xt[COORD_BITS-1:0];
    end
  end

  // stage 4: full product, saturated above 2^50
  logic [80:0] full4;
  logic        sat4;
  logic [51:0] m4_d;
  always_comb begin
    full4 = {phi3_q, 25'h0} + 81'(plo3_q);
    sat4  = (full4[80:51] != 30'h0) || (full4[50] && (full4[49:0] != 50'h0));
    m4_d  = sat4 ? {1'b1, 51'h0} : full4[51:0];
  end

  // stage 5: apply sign and add the row position
  logic signed [52:0] base5, mag5, s5_d;
  always_comb begin
    base5 = 53'($signed({cfg_i.y_position, 32'h0000_0000}));
    mag5  = $signed({1'b0, m4_q});
    s5_d  = neg4_q ? base5 - mag5 : base5 + mag5;
  end

  // stage 6: y truncated toward zero, clamped to screen, clipped
  logic signed [20:0]           yq, yt, yc, h21, ylo, yhi;
  logic signed [COORD_BITS-1:0] py6_d;
  always_comb begin
    yq  = s5_q[52:32];
    yt  = yq + 21'(s5_q[52] && (s5_q[31:0] != 32'h0));
    h21 = $signed({6'b0, cfg_i.screen_height});
    ylo = -h21;
    yhi = h21 <<< 1;
    if (yt < ylo) begin
      yc = ylo;
    end else if (yt > yhi) begin
      yc = yhi;
    end else begin
      yc = yt;
    end
    if (yc > YQ_MAX) begin
      py6_d = C_MAX;
    end else if (yc < YQ_MIN) begin
      py6_d = C_MIN;
    end else begin
      py6_d = yc[COORD_BITS-1:0];
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rs1_q    <= record_start_i;
      xprod1_q <= xprod1_d;
      diff1_q  <= diff1_d;
      rs2_q    <= rs1_q;
      xs2_q    <= xs2_d;
      a2_q     <= a2_d;
      b2_q     <= gabs[31:0];
      neg2_q   <= diff1_q[49] ^ cfg_i.y_gain[31];
      rs3_q    <= rs2_q;
      px3_q    <= px3_d;
      plo3_q   <= 57'(a2_q[24:0]) * 57'(b2_q);
      phi3_q   <= 56'(a2_q[48:25]) * 56'(b2_q);
      neg3_q   <= neg2_q;
      rs4_q    <= rs3_q;
      px4_q    <= px3_q;
      m4_q     <= m4_d;
      neg4_q   <= neg3_q;
      rs5_q    <= rs4_q;
      px5_q    <= px4_q;
      s5_q     <= s5_d;
      rs6_q    <= rs5_q;
      px6_q    <= px5_q;
      py6_q    <= py6_d;
    end
  end

  // run state
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, emitted_x_q, emitted_y_q;
  logic                         any_emitted_q, cursor_found_q;

  // classify the point: leading previous point, half step, the point itself
  logic                         first, slow, emit_mid, emit_pt, hit;
  logic signed [COORD_BITS-1:0] ex, ey, midx;
  logic signed [COORD_BITS:0]   msum, madj;
  logic signed [16:0]           x17, cur17;
  stpg_pt_t                     pt_prev, pt_mid, pt_cur;
  always_comb begin
    first    = !any_emitted_q;
    ex       = first ? prev_x_q : emitted_x_q;
    ey       = first ? prev_y_q : emitted_y_q;
    slow     = (cfg_i.x_scale[23:16] == 8'h00);
    msum     = (COORD_BITS + 1)'(prev_x_q) + (COORD_BITS + 1)'(px6_q);
    madj     = msum + (COORD_BITS + 1)'(msum[COORD_BITS] & msum[0]);
    midx     = madj[COORD_BITS:1];
    emit_mid = !slow && (midx != px6_q);
    emit_pt  = slow ? ((ex != px6_q) || (ey != py6_q)) : 1'b1;
    x17      = 17'(px6_q);
    cur17    = cfg_i.cursor_column;
    hit      = !cursor_found_q && (x17 >= cur17);
    pt_prev  = '{x: PT_BITS'(prev_x_q), y: PT_BITS'(prev_y_q)};
    pt_mid   = '{x: PT_BITS'(midx), y: PT_BITS'(py6_q)};
    pt_cur   = '{x: PT_BITS'(px6_q), y: PT_BITS'(py6_q)};

    q_rec_o.pt[0] = first ? pt_prev : (emit_mid ? pt_mid : pt_cur);
    q_rec_o.pt[1] = first ? (emit_mid ? pt_mid : pt_cur) : pt_cur;
    q_rec_o.pt[2] = pt_cur;
    q_rec_o.cnt   = 2'(first) + 2'(emit_mid) + 2'(emit_pt);
    q_rec_o.hit   = hit;
    q_push_o      = adv && v6_q && !rs6_q && (q_rec_o.cnt != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q       <= '0;
      prev_y_q       <= '0;
      emitted_x_q    <= '0;
      emitted_y_q    <= '0;
      any_emitted_q  <= 1'b0;
      cursor_found_q <= 1'b0;
    end else if (adv && v6_q) begin
      prev_x_q <= px6_q;
      prev_y_q <= py6_q;
      if (rs6_q) begin
        any_emitted_q  <= 1'b0;
        cursor_found_q <= 1'b0;
      end else begin
        any_emitted_q  <= 1'b1;
        cursor_found_q <= cursor_found_q | hit;
        emitted_x_q    <= emit_pt ? px6_q : ex;
        emitted_y_q    <= emit_pt ? py6_q : ey;
      end
    end
  end

  // checks
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_full_i)
    else $error("record pushed into a full queue");
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v6_q && rs6_q) |=> (!any_emitted_q && !cursor_found_q))
    else $error("record start left run state set");
  a_first_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v6_q && !rs6_q && !any_emitted_q) |-> q_push_o)
    else $error("first point of a run not pushed");

endmodule

// File: design/stpg_queue.sv
// Short record queue between the front and back parts.
// Depends on stpg_pkg for the record type and depth.
module stpg_queue import stpg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  stpg_rec_t rec_i,
  output logic      full_o,
  input  logic      pop_i,
  output stpg_rec_t rec_o,
  output logic      empty_o
);

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  stpg_rec_t       mem_q [QDEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QDEPTH))
    else $error("queue count past depth");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("queue count missed a push");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CW'(QDEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// File: design/stpg_back.sv
// Back part: walks the head record and hands out one vertex per request.
// Depends on stpg_pkg for the record type.
module stpg_back import stpg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stpg_rec_t          rec_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  input  logic               pop,
  output logic               empty,
  output logic [PT_BITS-1:0] point_x_o,
  output logic [PT_BITS-1:0] point_y_o,
  output logic               at_cursor_o,
  output logic               last_of_run_o
);

  logic [1:0] k_q;
  logic       last;

  // current slot of the head record
  always_comb begin
    last          = (k_q == 2'(rec_i.cnt - 2'd1));
    empty         = q_empty_i;
    point_x_o     = rec_i.pt[k_q].x;
    point_y_o     = rec_i.pt[k_q].y;
    last_of_run_o = last;
    at_cursor_o   = last && rec_i.hit;
    q_pop_o       = pop && !q_empty_i && last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= 2'd0;
    end else if (pop && !q_empty_i) begin
      k_q <= last ? 2'd0 : k_q + 2'd1;
    end
  end

  // checks
  a_rec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> (rec_i.cnt != 2'd0))
    else $error("empty record reached the back part");
  a_slot_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != 2'd0) |-> !q_empty_i)
    else $error("slot index set with no record");
  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !q_empty_i && !last) |=> (k_q == $past(k_q) + 2'd1))
    else $error("slot index did not step");

endmodule

// File: design/scope_trace_point_generator_top.sv
// Top level of the scope trace point generator: configuration registers,
// front mapping pipeline, record queue and back vertex sequencer.
// Depends on stpg_pkg, stpg_front, stpg_queue and stpg_back.
//
//   channel   handshake            payload
//   -------   ------------------   -------------------------------------------
//   input     push / full          sample_raw_i, sample_index_i, record_start_i
//   result    empty / pop          point_x_o, point_y_o, at_cursor_o,
//                                  last_of_run_o
//   config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// A sample is taken every cycle while the record queue has room; it passes
// through the registered mapping stages on its way to the queue. Each sample
// gives zero to three vertices; the back part hands out one vertex per cycle
// while pop is high and a record waits; the single result port sets the rate.
// A full queue freezes the whole mapping pipeline and raises full.
// Reset clears configuration to defaults and the run state to zero.
module scope_trace_point_generator_top import stpg_pkg::*; #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     push,
  output logic                     full,
  input  logic [31:0]              sample_raw_i,
  input  logic [INDEX_BITS-1:0]    sample_index_i,
  input  logic                     record_start_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [PT_BITS-1:0]       point_x_o,
  output logic [PT_BITS-1:0]       point_y_o,
  output logic                     at_cursor_o,
  output logic                     last_of_run_o
);

  stpg_cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (stpg_reg_e'(cfg_idx_i))
        REG_X_SCALE:       cfg_d.x_scale       = cfg_wdata_i[23:0];
        REG_X_OFFSET:      cfg_d.x_offset      = cfg_wdata_i[31:0];
        REG_Y_GAIN:        cfg_d.y_gain        = cfg_wdata_i[31:0];
        REG_VALUE_OFFSET:  cfg_d.value_offset  = cfg_wdata_i[31:0];
        REG_Y_POSITION:    cfg_d.y_position    = cfg_wdata_i[15:0];
        REG_SCREEN_HEIGHT: cfg_d.screen_height = cfg_wdata_i[14:0];
        REG_SAMPLE_TYPE:   cfg_d.sample_type   = stpg_stype_e'(cfg_wdata_i[1:0]);
        REG_CURSOR_COLUMN: cfg_d.cursor_column = cfg_wdata_i[16:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_scale       <= RST_X_SCALE;
      cfg_q.x_offset      <= RST_X_OFFSET;
      cfg_q.y_gain        <= RST_Y_GAIN;
      cfg_q.value_offset  <= RST_VALUE_OFFSET;
      cfg_q.y_position    <= RST_Y_POSITION;
      cfg_q.screen_height <= RST_SCREEN_HEIGHT;
      cfg_q.sample_type   <= STYPE_BIT;
      cfg_q.cursor_column <= RST_CURSOR_COLUMN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic      q_push, q_full, q_pop, q_empty;
  stpg_rec_t q_wr_rec, q_rd_rec;

  assign full = q_full;

  stpg_front #(
    .INDEX_BITS (INDEX_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_push_i      (push),
    .sample_raw_i   (sample_raw_i),
    .sample_index_i (sample_index_i),
    .record_start_i (record_start_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_rec_o        (q_wr_rec)
  );

  stpg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (q_wr_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rec_o   (q_rd_rec),
    .empty_o (q_empty)
  );

  stpg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_i         (q_rd_rec),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .pop           (pop),
    .empty         (empty),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .at_cursor_o   (at_cursor_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: tb/stpg_point_checker.sv
// Scoreboard for the scope trace point generator: watches the register writes,
// the sample requests and the vertex requests, predicts and compares.
// Depends on stpg_pkg only.
`timescale 1ns / 100ps

module stpg_point_checker import stpg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     push,
  input  logic                     full,
  input  logic [31:0]              sample_raw_i,
  input  logic [15:0]              sample_index_i,
  input  logic                     record_start_i,
  input  logic                     empty,
  input  logic                     pop,
  input  logic [PT_BITS-1:0]       point_x_o,
  input  logic [PT_BITS-1:0]       point_y_o,
  input  logic                     at_cursor_o,
  input  logic                     last_of_run_o,
  output int                       mismatch_cnt_o,
  output int                       pending_o
);

  localparam longint COORD_MAX = 32767;
  localparam longint COORD_MIN = -32768;
  // Product magnitude above which the y term saturates, and its saturated value.
  localparam longint PROD_LIMIT = 64'sh0004_0000_0000_0000;
  localparam longint PROD_SAT   = 64'sh0008_0000_0000_0000;

  typedef struct packed {
    logic [PT_BITS-1:0] x;
    logic [PT_BITS-1:0] y;
    logic               at_cursor;
    logic               last;
  } vertex_t;

  stpg_cfg_t view;
  longint    prev_x, prev_y, drawn_x, drawn_y;
  logic      run_open, cursor_seen;
  vertex_t   vertex_q[$];

  function automatic longint shift_to_zero(longint v, int sh);
    if (v >= 0) return v >>> sh;
    return -((-v) >>> sh);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Sample word and index to a screen point.
  function automatic void map_to_screen(input logic [31:0] raw, input logic [15:0] idx,
                                        output longint px, output longint py);
    longint xs, val, diff, gain, a, b, mag, s, y, h;
    logic   neg;
    xs = longint'(idx) * longint'(view.x_scale) - longint'(signed'(view.x_offset));
    px = clamp(shift_to_zero(xs, 16), COORD_MIN, COORD_MAX);
    case (view.sample_type)
      STYPE_BIT:    val = (raw != 32'd0) ? 65536 : 0;
      STYPE_REAL:   val = longint'(signed'(raw));
      STYPE_SIGNED: val = longint'(signed'(raw)) * 65536;
      default:      val = longint'(raw) * 65536;
    endcase
    diff = val - longint'(signed'(view.value_offset));
    gain = longint'(signed'(view.y_gain));
    neg  = (diff < 0) != (gain < 0);
    a    = (diff < 0) ? -diff : diff;
    b    = (gain < 0) ? -gain : gain;
    // saturate huge products; the clamp below hides the difference
    if (a == 0 || b == 0) mag = 0;
    else if (a > PROD_LIMIT / b) mag = PROD_SAT;
    else mag = a * b;
    s  = neg ? -mag : mag;
    s  = s + longint'(signed'(view.y_position)) * 64'sh1_0000_0000;
    y  = shift_to_zero(s, 32);
    h  = longint'(view.screen_height);
    y  = clamp(y, -h, 2 * h);
    py = clamp(y, COORD_MIN, COORD_MAX);
  endfunction

  // Vertices caused by one accepted sample, appended to the queue.
  function automatic void predict_vertices(input logic [31:0] raw, input logic [15:0] idx,
                                           input logic start);
    longint  x, y, midx;
    longint  vx[3], vy[3];
    int      cnt;
    logic    hit;
    vertex_t v;
    map_to_screen(raw, idx, x, y);
    if (start) begin
      prev_x      = x;
      prev_y      = y;
      run_open    = 1'b0;
      cursor_seen = 1'b0;
      return;
    end
    cnt = 0;
    hit = 1'b0;
    // first vertex of a run is the previous point
    if (!run_open) begin
      vx[cnt] = prev_x;
      vy[cnt] = prev_y;
      cnt++;
      drawn_x  = prev_x;
      drawn_y  = prev_y;
      run_open = 1'b1;
    end
    if (view.x_scale < 24'h010000) begin
      // dense samples: drop repeats of the last vertex
      if (drawn_x != x || drawn_y != y) begin
        vx[cnt] = x;
        vy[cnt] = y;
        cnt++;
      end
    end else begin
      midx = (prev_x + x) / 2;
      if (midx != x) begin
        vx[cnt] = midx;
        vy[cnt] = y;
        cnt++;
      end
      vx[cnt] = x;
      vy[cnt] = y;
      cnt++;
    end
    if (cnt > 0) begin
      drawn_x = vx[cnt-1];
      drawn_y = vy[cnt-1];
    end
    if (!cursor_seen && x >= longint'(signed'(view.cursor_column))) begin
      cursor_seen = 1'b1;
      hit         = 1'b1;
    end
    prev_x = x;
    prev_y = y;
    for (int k = 0; k < cnt; k++) begin
      v.x         = vx[k][PT_BITS-1:0];
      v.y         = vy[k][PT_BITS-1:0];
      v.last      = (k == cnt - 1);
      v.at_cursor = v.last && hit;
      vertex_q.push_back(v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t want;
    if (!rst_ni) begin
      view.x_scale       = RST_X_SCALE;
      view.x_offset      = RST_X_OFFSET;
      view.y_gain        = RST_Y_GAIN;
      view.value_offset  = RST_VALUE_OFFSET;
      view.y_position    = RST_Y_POSITION;
      view.screen_height = RST_SCREEN_HEIGHT;
      view.sample_type   = STYPE_BIT;
      view.cursor_column = RST_CURSOR_COLUMN;
      prev_x         = 0;
      prev_y         = 0;
      drawn_x        = 0;
      drawn_y        = 0;
      run_open       = 1'b0;
      cursor_seen    = 1'b0;
      vertex_q.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
    end else begin
      // register write
      if (cfg_we_i) begin
        case (stpg_reg_e'(cfg_idx_i))
          REG_X_SCALE:       view.x_scale       = cfg_wdata_i[23:0];
          REG_X_OFFSET:      view.x_offset      = cfg_wdata_i[31:0];
          REG_Y_GAIN:        view.y_gain        = cfg_wdata_i[31:0];
          REG_VALUE_OFFSET:  view.value_offset  = cfg_wdata_i[31:0];
          REG_Y_POSITION:    view.y_position    = cfg_wdata_i[15:0];
          REG_SCREEN_HEIGHT: view.screen_height = cfg_wdata_i[14:0];
          REG_SAMPLE_TYPE:   view.sample_type   = stpg_stype_e'(cfg_wdata_i[1:0]);
          REG_CURSOR_COLUMN: view.cursor_column = cfg_wdata_i[16:0];
          default: ;
        endcase
      end
      // vertex request against the oldest prediction
      if (pop && !empty) begin
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected vertex x=%0d y=%0d cursor=%b last=%b", $time,
                   $signed(point_x_o), $signed(point_y_o), at_cursor_o, last_of_run_o);
          mismatch_cnt_o++;
        end else begin
          want = vertex_q.pop_front();
          if (point_x_o !== want.x) begin
            $display("%0t: point_x expected %0d, actual %0d", $time,
                     $signed(want.x), $signed(point_x_o));
            mismatch_cnt_o++;
          end
          if (point_y_o !== want.y) begin
            $display("%0t: point_y expected %0d, actual %0d", $time,
                     $signed(want.y), $signed(point_y_o));
            mismatch_cnt_o++;
          end
          if (at_cursor_o !== want.at_cursor) begin
            $display("%0t: at_cursor expected %b, actual %b", $time,
                     want.at_cursor, at_cursor_o);
            mismatch_cnt_o++;
          end
          if (last_of_run_o !== want.last) begin
            $display("%0t: last_of_run expected %b, actual %b", $time,
                     want.last, last_of_run_o);
            mismatch_cnt_o++;
          end
        end
      end
      // sample request
      if (push && !full)
        predict_vertices(sample_raw_i, sample_index_i, record_start_i);
      pending_o = vertex_q.size();
    end
  end

endmodule

// File: tb/scope_trace_point_generator_top_tb.sv
// Testbench top for the scope trace point generator: clock, reset, register
// writes, sample and vertex traffic with random gaps, and the verdict.
// Depends on stpg_pkg, the design and stpg_point_checker.
`timescale 1ns / 100ps

module scope_trace_point_generator_top_tb import stpg_pkg::*;;

  localparam int SETTLE_CYCLES  = 12;
  localparam int RX_HOLD_CYCLES = 100;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [2:0]               cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic                     push;
  logic                     full;
  logic [31:0]              sample_raw;
  logic [15:0]              sample_index;
  logic                     record_start;
  logic                     empty;
  logic                     pop;
  logic [PT_BITS-1:0]       point_x;
  logic [PT_BITS-1:0]       point_y;
  logic                     at_cursor;
  logic                     last_of_run;
  int                       mismatches;
  int                       pending;

  stpg_cfg_t view;
  int        tx_gap_max = 13;
  int        rx_gap_max = 13;
  bit        rx_hold    = 1'b0;

  scope_trace_point_generator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .push          (push),
    .full          (full),
    .sample_raw_i  (sample_raw),
    .sample_index_i(sample_index),
    .record_start_i(record_start),
    .empty         (empty),
    .pop           (pop),
    .point_x_o     (point_x),
    .point_y_o     (point_y),
    .at_cursor_o   (at_cursor),
    .last_of_run_o (last_of_run)
  );

  stpg_point_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .push          (push),
    .full          (full),
    .sample_raw_i  (sample_raw),
    .sample_index_i(sample_index),
    .record_start_i(record_start),
    .empty         (empty),
    .pop           (pop),
    .point_x_o     (point_x),
    .point_y_o     (point_y),
    .at_cursor_o   (at_cursor),
    .last_of_run_o (last_of_run),
    .mismatch_cnt_o(mismatches),
    .pending_o     (pending)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Register write; write enable stays up for back-to-back writes.
  task automatic write_reg(input stpg_reg_e r, input logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= d;
    @(posedge clk_i);
  endtask

  task automatic write_view();
    write_reg(REG_X_SCALE,       32'(view.x_scale));
    write_reg(REG_X_OFFSET,      view.x_offset);
    write_reg(REG_Y_GAIN,        view.y_gain);
    write_reg(REG_VALUE_OFFSET,  view.value_offset);
    write_reg(REG_Y_POSITION,    32'(view.y_position));
    write_reg(REG_SCREEN_HEIGHT, 32'(view.screen_height));
    write_reg(REG_SAMPLE_TYPE,   32'(view.sample_type));
    write_reg(REG_CURSOR_COLUMN, 32'(view.cursor_column));
    cfg_we <= 1'b0;
  endtask

  // One sample request after a random gap.
  task automatic send_sample(input logic [31:0] raw, input logic [15:0] idx,
                             input logic start);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    repeat (gap) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    sample_raw   <= raw;
    sample_index <= idx;
    record_start <= start;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted vertex has been taken.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly small values near the screen, sometimes a full random word.
  function automatic logic [31:0] pick_raw();
    int k;
    if ($urandom_range(0, 3) == 0) return $urandom();
    k = int'($urandom_range(0, 40)) - 20;
    case (view.sample_type)
      STYPE_BIT:    return ($urandom_range(0, 1) == 0) ? 32'd0 : 32'(k);
      STYPE_REAL:   return 32'(k * 65536 + int'($urandom_range(0, 65535)));
      STYPE_SIGNED: return 32'(k);
      default:      return 32'($urandom_range(0, 40));
    endcase
  endfunction

  // Random settings, then runs of consecutive samples with some noise.
  // With hold set, the receiver stops for a long stretch once sending starts.
  task automatic run_random_phase(input int n_items, input bit hold = 1'b0);
    int          left, run_len, stride, kind;
    logic [15:0] idx;
    logic [31:0] raw;
    settle();
    case ($urandom_range(0, 3))
      0:       view.x_scale = 24'($urandom_range(0, 24'h00FFFF));
      1:       view.x_scale = 24'h010000;
      2:       view.x_scale = 24'($urandom_range(24'h010000, 24'h080000));
      default: view.x_scale = 24'($urandom());
    endcase
    view.x_offset     = ($urandom_range(0, 3) == 0) ? $urandom() :
                        32'((int'($urandom_range(0, 200)) - 100) * 65536);
    view.y_gain       = ($urandom_range(0, 3) == 0) ? $urandom() :
                        32'((int'($urandom_range(0, 16)) - 8) * 16384);
    view.value_offset = ($urandom_range(0, 3) == 0) ? $urandom() :
                        32'((int'($urandom_range(0, 20)) - 10) * 65536);
    view.y_position    = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                         16'($urandom_range(0, 600));
    view.screen_height = ($urandom_range(0, 3) == 0) ? 15'($urandom()) :
                         15'($urandom_range(1, 600));
    view.sample_type   = stpg_stype_e'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       view.cursor_column = 17'h08000;
      1:       view.cursor_column = 17'h18000;
      2:       view.cursor_column = 17'($urandom_range(0, 200));
      default: view.cursor_column = 17'($urandom());
    endcase
    write_view();
    if (hold) rx_hold = 1'b1;
    left = n_items;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_sample($urandom(), 16'($urandom()), 1'($urandom()));
        left--;
      end else begin
        idx = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 64));
        // kind 1 carries on the run state left from before
        if (kind != 1) begin
          send_sample(pick_raw(), idx, 1'b1);
          left--;
        end
        run_len = $urandom_range(3, 10);
        stride  = $urandom_range(1, 3);
        raw     = pick_raw();
        repeat (run_len) begin
          if ($urandom_range(0, 4) != 0) raw = pick_raw();
          idx = idx + 16'(stride);
          send_sample(raw, idx, 1'b0);
          left--;
        end
      end
    end
  endtask

  // Vertex receiver: random gap per request, one long hold when asked.
  initial begin
    int gap;
    pop <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold) begin
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      gap = $urandom_range(0, rx_gap_max);
      repeat (gap) begin
        pop <= 1'b0;
        @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin
    rst_ni       <= 1'b0;
    push         <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_X_SCALE;
    cfg_wdata    <= '0;
    sample_raw   <= '0;
    sample_index <= '0;
    record_start <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, no record start yet: previous point is the origin
    send_sample(32'd1, 16'd5, 1'b0);
    send_sample(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_sample(32'd0, 16'd0, 1'b1);
    send_sample(32'd0, 16'd0, 1'b0);

    // widest scale, extreme offsets and gain: huge products saturate
    settle();
    view.x_scale       = 24'hFF_FFFF;
    view.x_offset      = 32'h8000_0000;
    view.y_gain        = 32'h7FFF_FFFF;
    view.value_offset  = 32'h8000_0000;
    view.y_position    = 16'h7FFF;
    view.screen_height = 15'h7FFF;
    view.sample_type   = STYPE_UNSIGNED;
    view.cursor_column = 17'd0;
    write_view();
    send_sample(32'd0, 16'd0, 1'b1);
    send_sample(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_sample(32'd0, 16'd1, 1'b0);
    send_sample(32'h8000_0000, 16'd2, 1'b0);

    // zero scale and zero height: every point repeats and is dropped
    settle();
    view.x_scale       = 24'd0;
    view.x_offset      = 32'h7FFF_FFFF;
    view.y_gain        = 32'h8000_0000;
    view.value_offset  = 32'h7FFF_FFFF;
    view.y_position    = 16'h8000;
    view.screen_height = 15'd0;
    view.sample_type   = STYPE_REAL;
    view.cursor_column = 17'h18000;
    write_view();
    send_sample(32'h7FFF_FFFF, 16'd0, 1'b1);
    send_sample(32'h7FFF_FFFF, 16'd1, 1'b0);
    send_sample(32'h8000_0000, 16'd2, 1'b0);

    // quarter pixel per sample, cursor disabled
    settle();
    view.x_scale       = 24'h00_4000;
    view.x_offset      = 32'd0;
    view.y_gain        = 32'hFFFF_0000;
    view.value_offset  = 32'd0;
    view.y_position    = 16'd240;
    view.screen_height = 15'd480;
    view.sample_type   = STYPE_SIGNED;
    view.cursor_column = 17'h08000;
    write_view();
    send_sample(32'd0, 16'd0, 1'b1);
    send_sample(32'd5, 16'd4, 1'b0);
    send_sample(32'd5, 16'd8, 1'b0);
    send_sample(32'hFFFF_FFFD, 16'd9, 1'b0);
    send_sample(32'd10, 16'd12, 1'b0);

    // cursor lands on a repeat of the last vertex: found, nothing marked
    settle();
    view.cursor_column = 17'd3;
    write_view();
    send_sample(32'd10, 16'd12, 1'b0);
    send_sample(32'd10, 16'd13, 1'b0);
    send_sample(32'd11, 16'd16, 1'b0);

    // random part
    run_random_phase(21);
    tx_gap_max = 0;
    rx_gap_max = 0;
    run_random_phase(21);
    // receiver holds off while samples keep coming: queue fills
    rx_gap_max = 13;
    run_random_phase(24, 1'b1);
    tx_gap_max = 13;
    repeat (2) run_random_phase(21);
    rx_gap_max = 0;
    run_random_phase(21);
    rx_gap_max = 13;

    settle();
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
